// File: rtl/rvd_pkg.sv
// rvd_pkg: opcodes, mnemonic codes, result record and funct3 lookup
// functions for the RV64I instruction decoder.
// No dependencies.
package rvd_pkg;

    localparam int INSTR_W = 32;
    localparam int MN_W    = 6;
    localparam int REG_W   = 5;
    localparam int IMM_W   = 21;
    localparam int OUT_W   = 48;   // 42 payload bits padded to whole bytes

    // major opcodes, bits 6:0
    localparam logic [6:0] OP_R      = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [5:0] F6_BASE = 6'b000000;
    localparam logic [5:0] F6_SRA  = 6'b010000;

    // funct3 values referenced by name
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SRL = 3'd5;

    // mnemonic codes
    localparam logic [MN_W-1:0] MN_NONE  = 6'd0;
    localparam logic [MN_W-1:0] MN_ADD   = 6'd1;
    localparam logic [MN_W-1:0] MN_SUB   = 6'd2;
    localparam logic [MN_W-1:0] MN_XOR   = 6'd3;
    localparam logic [MN_W-1:0] MN_OR    = 6'd4;
    localparam logic [MN_W-1:0] MN_AND   = 6'd5;
    localparam logic [MN_W-1:0] MN_SLL   = 6'd6;
    localparam logic [MN_W-1:0] MN_SRL   = 6'd7;
    localparam logic [MN_W-1:0] MN_SRA   = 6'd8;
    localparam logic [MN_W-1:0] MN_SLT   = 6'd9;
    localparam logic [MN_W-1:0] MN_SLTU  = 6'd10;
    localparam logic [MN_W-1:0] MN_LB    = 6'd11;
    localparam logic [MN_W-1:0] MN_LH    = 6'd12;
    localparam logic [MN_W-1:0] MN_LW    = 6'd13;
    localparam logic [MN_W-1:0] MN_LD    = 6'd14;
    localparam logic [MN_W-1:0] MN_LBU   = 6'd15;
    localparam logic [MN_W-1:0] MN_LHU   = 6'd16;
    localparam logic [MN_W-1:0] MN_LWU   = 6'd17;
    localparam logic [MN_W-1:0] MN_JALR  = 6'd18;
    localparam logic [MN_W-1:0] MN_ADDI  = 6'd19;
    localparam logic [MN_W-1:0] MN_XORI  = 6'd20;
    localparam logic [MN_W-1:0] MN_ORI   = 6'd21;
    localparam logic [MN_W-1:0] MN_ANDI  = 6'd22;
    localparam logic [MN_W-1:0] MN_SLLI  = 6'd23;
    localparam logic [MN_W-1:0] MN_SRLI  = 6'd24;
    localparam logic [MN_W-1:0] MN_SRAI  = 6'd25;
    localparam logic [MN_W-1:0] MN_SLTI  = 6'd26;
    localparam logic [MN_W-1:0] MN_SLTIU = 6'd27;
    localparam logic [MN_W-1:0] MN_SB    = 6'd28;
    localparam logic [MN_W-1:0] MN_SH    = 6'd29;
    localparam logic [MN_W-1:0] MN_SW    = 6'd30;
    localparam logic [MN_W-1:0] MN_SD    = 6'd31;
    localparam logic [MN_W-1:0] MN_BEQ   = 6'd32;
    localparam logic [MN_W-1:0] MN_BNE   = 6'd33;
    localparam logic [MN_W-1:0] MN_BLT   = 6'd34;
    localparam logic [MN_W-1:0] MN_BGE   = 6'd35;
    localparam logic [MN_W-1:0] MN_BLTU  = 6'd36;
    localparam logic [MN_W-1:0] MN_BGEU  = 6'd37;
    localparam logic [MN_W-1:0] MN_JAL   = 6'd38;
    localparam logic [MN_W-1:0] MN_LUI   = 6'd39;

    // decoded result; mnemonic sits in the low bits when packed
    typedef struct packed {
        logic signed [IMM_W-1:0] immediate;
        logic [REG_W-1:0]        src2_reg;
        logic [REG_W-1:0]        src1_reg;
        logic [REG_W-1:0]        dest_reg;
        logic [MN_W-1:0]         mnemonic;
    } rvd_result_t;

    function automatic logic [MN_W-1:0] r_code(input logic [2:0] f3);
        logic [MN_W-1:0] c;
        case (f3)
            3'd0:    c = MN_ADD;
            3'd1:    c = MN_SLL;
            3'd2:    c = MN_SLT;
            3'd3:    c = MN_SLTU;
            3'd4:    c = MN_XOR;
            3'd5:    c = MN_SRL;
            3'd6:    c = MN_OR;
            3'd7:    c = MN_AND;
            default: c = MN_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [MN_W-1:0] load_code(input logic [2:0] f3);
        logic [MN_W-1:0] c;
        case (f3)
            3'd0:    c = MN_LB;
            3'd1:    c = MN_LH;
            3'd2:    c = MN_LW;
            3'd3:    c = MN_LD;
            3'd4:    c = MN_LBU;
            3'd5:    c = MN_LHU;
            3'd6:    c = MN_LWU;
            default: c = MN_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [MN_W-1:0] imm_code(input logic [2:0] f3);
        logic [MN_W-1:0] c;
        case (f3)
            3'd0:    c = MN_ADDI;
            3'd2:    c = MN_SLTI;
            3'd3:    c = MN_SLTIU;
            3'd4:    c = MN_XORI;
            3'd6:    c = MN_ORI;
            3'd7:    c = MN_ANDI;
            default: c = MN_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [MN_W-1:0] store_code(input logic [2:0] f3);
        logic [MN_W-1:0] c;
        case (f3)
            3'd0:    c = MN_SB;
            3'd1:    c = MN_SH;
            3'd2:    c = MN_SW;
            3'd3:    c = MN_SD;
            default: c = MN_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [MN_W-1:0] branch_code(input logic [2:0] f3);
        logic [MN_W-1:0] c;
        case (f3)
            3'd0:    c = MN_BEQ;
            3'd1:    c = MN_BNE;
            3'd4:    c = MN_BLT;
            3'd5:    c = MN_BGE;
            3'd6:    c = MN_BLTU;
            3'd7:    c = MN_BGEU;
            default: c = MN_NONE;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/rvd_decode.sv
// rvd_decode: combinational field extraction and opcode/funct compare for
// one instruction word. Depends on rvd_pkg.
module rvd_decode (
    input  logic [rvd_pkg::INSTR_W-1:0] instr_word,
    output rvd_pkg::rvd_result_t        result
);
    import rvd_pkg::*;

    logic [6:0]       op;
    logic [2:0]       f3;
    logic [6:0]       f7;
    logic [5:0]       f6;
    logic [MN_W-1:0]  code;
    logic [IMM_W-1:0] imm;
    logic             use_rd;
    logic             use_r1;
    logic             use_r2;

    // immediate formats, all widened to 21 bits
    logic [IMM_W-1:0] imm_i;
    logic [IMM_W-1:0] imm_s;
    logic [IMM_W-1:0] imm_b;
    logic [IMM_W-1:0] imm_j;
    logic [IMM_W-1:0] imm_sh;
    logic [IMM_W-1:0] imm_u;

    assign op = instr_word[6:0];
    assign f3 = instr_word[14:12];
    assign f7 = instr_word[31:25];
    assign f6 = instr_word[31:26];

    assign imm_i  = {{9{instr_word[31]}}, instr_word[31:20]};
    assign imm_s  = {{9{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b  = {{8{instr_word[31]}}, instr_word[31], instr_word[7],
                     instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_j  = {instr_word[31], instr_word[19:12], instr_word[20],
                     instr_word[30:21], 1'b0};
    assign imm_sh = {15'd0, instr_word[25:20]};
    assign imm_u  = {1'b0, instr_word[31:12]};

    always_comb
    begin
        code   = MN_NONE;
        imm    = '0;
        use_rd = 1'b0;
        use_r1 = 1'b0;
        use_r2 = 1'b0;
        case (op)
            OP_R:
            begin
                if (f7 == F7_BASE)
                    code = r_code(f3);
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    code = MN_SUB;
                else if (f7 == F7_ALT && f3 == F3_SRL)
                    code = MN_SRA;
                use_rd = 1'b1;
                use_r1 = 1'b1;
                use_r2 = 1'b1;
            end
            OP_LOAD:
            begin
                code   = load_code(f3);
                imm    = imm_i;
                use_rd = 1'b1;
                use_r1 = 1'b1;
            end
            OP_JALR:
            begin
                code   = MN_JALR;
                imm    = imm_i;
                use_rd = 1'b1;
                use_r1 = 1'b1;
            end
            OP_IMM:
            begin
                if (f3 == F3_SLL || f3 == F3_SRL)
                begin
                    if (f3 == F3_SLL && f6 == F6_BASE)
                        code = MN_SLLI;
                    else if (f3 == F3_SRL && f6 == F6_BASE)
                        code = MN_SRLI;
                    else if (f3 == F3_SRL && f6 == F6_SRA)
                        code = MN_SRAI;
                    imm = imm_sh;
                end
                else
                begin
                    code = imm_code(f3);
                    imm  = imm_i;
                end
                use_rd = 1'b1;
                use_r1 = 1'b1;
            end
            OP_STORE:
            begin
                code   = store_code(f3);
                imm    = imm_s;
                use_r1 = 1'b1;
                use_r2 = 1'b1;
            end
            OP_BRANCH:
            begin
                code   = branch_code(f3);
                imm    = imm_b;
                use_r1 = 1'b1;
                use_r2 = 1'b1;
            end
            OP_JAL:
            begin
                code   = MN_JAL;
                imm    = imm_j;
                use_rd = 1'b1;
            end
            OP_LUI:
            begin
                code   = MN_LUI;
                imm    = imm_u;
                use_rd = 1'b1;
            end
            default:
            begin
                code = MN_NONE;
            end
        endcase
    end

    // unrecognised word: every field zero
    always_comb
    begin
        result.mnemonic = code;
        if (code == MN_NONE)
        begin
            result.dest_reg  = '0;
            result.src1_reg  = '0;
            result.src2_reg  = '0;
            result.immediate = '0;
        end
        else
        begin
            result.dest_reg  = use_rd ? instr_word[11:7]  : '0;
            result.src1_reg  = use_r1 ? instr_word[19:15] : '0;
            result.src2_reg  = use_r2 ? instr_word[24:20] : '0;
            result.immediate = imm;
        end
    end

endmodule

// File: rtl/rv64i_instruction_decoder.sv
// rv64i_instruction_decoder: top level, input beat register, decode logic
// and result register. Depends on rvd_pkg and rvd_decode.
//
// Decodes one 32-bit RV64I instruction word per beat into a mnemonic code
// (0 = not recognised), rd, rs1, rs2 and a 21-bit immediate. One beat is
// taken every clock cycle when the result side keeps up; a result appears
// on the master side once its word has passed through the input register
// and the decode logic into the result register. The input register
// and the result register form a two-entry pipeline, so a new word is
// taken while a finished result still waits for m_tready. Branch and jal
// offsets are sign-extended from bit 31; the lui immediate is the raw
// unsigned 20-bit field; shift immediates are zero-extended bits 25:20.
// Fields an instruction does not use come out as zero, and an
// unrecognised word gives an all-zero result.
module rv64i_instruction_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    // slave side
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rvd_pkg::INSTR_W-1:0]  s_tdata,   // [31:0] instr_word
    // master side
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rvd_pkg::OUT_W-1:0]    m_tdata    // [5:0] mnemonic,
                                                    // [10:6] dest_reg,
                                                    // [15:11] src1_reg,
                                                    // [20:16] src2_reg,
                                                    // [41:21] immediate,
                                                    // [47:42] zero
);
    import rvd_pkg::*;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [INSTR_W-1:0]  in_word_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    rvd_result_t         out_data_reg;
    rvd_result_t         dec_result;
    logic                out_load;

    // input word waiting and result register free, or emptying this cycle
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    rvd_decode u_decode (
        .instr_word (in_word_reg),
        .result     (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_word_reg <= s_tdata;
        if (out_load)
            out_data_reg <= dec_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - $bits(rvd_result_t)){1'b0}}, out_data_reg};

endmodule

// File: rtl/rvd_checker.sv
// rvd_checker: port-level assertions for rv64i_instruction_decoder, bound
// to the top level. Depends on rvd_pkg.
module rvd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [rvd_pkg::OUT_W-1:0]    m_tdata
);
    import rvd_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // code range and zero padding
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:0] <= MN_LUI && m_tdata[47:42] == 6'd0)
        else $error("mnemonic out of range or padding set");

    // unrecognised word gives an all-zero result
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5:0] == MN_NONE |-> m_tdata[41:6] == '0)
        else $error("unrecognised word with nonzero fields");

    // stores and branches write no register
    a_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5:0] >= MN_SB && m_tdata[5:0] <= MN_BGEU
        |-> m_tdata[10:6] == '0)
        else $error("store or branch with a destination register");

    // an empty pipeline always takes a beat
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("empty decoder not ready");

endmodule

bind rv64i_instruction_decoder rvd_checker u_rvd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/rv64i_instruction_decoder_checker.sv
// Scoreboard for the RV64I instruction decoder: snoops both stream channels,
// decodes every accepted instruction word on its own and checks each result beat.
// Depends on rvd_pkg for opcodes, mnemonic codes and the result record.
`timescale 1ns / 100ps

module rv64i_instruction_decoder_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [rvd_pkg::INSTR_W-1:0]  s_tdata,   // [31:0] instr_word
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [rvd_pkg::OUT_W-1:0]    m_tdata,   // [5:0] mnemonic, [10:6] dest_reg,
                                                    // [15:11] src1_reg, [20:16] src2_reg,
                                                    // [41:21] immediate, [47:42] zero
    output int                           fail_count,
    output int                           pending_results
);
    import rvd_pkg::*;

    localparam int PAYLOAD_W = MN_W + 3 * REG_W + IMM_W;

    // funct3 -> mnemonic, per opcode group
    localparam logic [MN_W-1:0] R_BASE_MN [0:7] =
        '{MN_ADD, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_OR, MN_AND};
    localparam logic [MN_W-1:0] LOAD_MN [0:7] =
        '{MN_LB, MN_LH, MN_LW, MN_LD, MN_LBU, MN_LHU, MN_LWU, MN_NONE};
    localparam logic [MN_W-1:0] IMM_MN [0:7] =
        '{MN_ADDI, MN_NONE, MN_SLTI, MN_SLTIU, MN_XORI, MN_NONE, MN_ORI, MN_ANDI};
    localparam logic [MN_W-1:0] STORE_MN [0:7] =
        '{MN_SB, MN_SH, MN_SW, MN_SD, MN_NONE, MN_NONE, MN_NONE, MN_NONE};
    localparam logic [MN_W-1:0] BRANCH_MN [0:7] =
        '{MN_BEQ, MN_BNE, MN_NONE, MN_NONE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};

    rvd_result_t decoded_q [$];
    int          errors = 0;

    function automatic rvd_result_t decode_word(input logic [INSTR_W-1:0] w);
        rvd_result_t r;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        use_rd;
        logic        use_rs1;
        logic        use_rs2;
        r       = '0;
        f3      = w[14:12];
        f7      = w[31:25];
        use_rd  = 1'b0;
        use_rs1 = 1'b0;
        use_rs2 = 1'b0;
        case (w[6:0])
            OP_R:
            begin
                if (f7 == F7_BASE)
                    r.mnemonic = R_BASE_MN[f3];
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    r.mnemonic = MN_SUB;
                else if (f7 == F7_ALT && f3 == F3_SRL)
                    r.mnemonic = MN_SRA;
                {use_rd, use_rs1, use_rs2} = 3'b111;
            end
            OP_LOAD:
            begin
                r.mnemonic  = LOAD_MN[f3];
                r.immediate = {{9{w[31]}}, w[31:20]};
                {use_rd, use_rs1} = 2'b11;
            end
            OP_JALR:
            begin
                // funct3 is not looked at
                r.mnemonic  = MN_JALR;
                r.immediate = {{9{w[31]}}, w[31:20]};
                {use_rd, use_rs1} = 2'b11;
            end
            OP_IMM:
            begin
                if (f3 == F3_SLL || f3 == F3_SRL)
                begin
                    // 6-bit shamt, upper six bits select the shift kind
                    if (f3 == F3_SLL && w[31:26] == F6_BASE)
                        r.mnemonic = MN_SLLI;
                    else if (f3 == F3_SRL && w[31:26] == F6_BASE)
                        r.mnemonic = MN_SRLI;
                    else if (f3 == F3_SRL && w[31:26] == F6_SRA)
                        r.mnemonic = MN_SRAI;
                    r.immediate = {15'b0, w[25:20]};
                end
                else
                begin
                    r.mnemonic  = IMM_MN[f3];
                    r.immediate = {{9{w[31]}}, w[31:20]};
                end
                {use_rd, use_rs1} = 2'b11;
            end
            OP_STORE:
            begin
                r.mnemonic  = STORE_MN[f3];
                r.immediate = {{9{w[31]}}, w[31:25], w[11:7]};
                {use_rs1, use_rs2} = 2'b11;
            end
            OP_BRANCH:
            begin
                r.mnemonic  = BRANCH_MN[f3];
                r.immediate = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                {use_rs1, use_rs2} = 2'b11;
            end
            OP_JAL:
            begin
                r.mnemonic  = MN_JAL;
                r.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                use_rd      = 1'b1;
            end
            OP_LUI:
            begin
                // raw upper field, not sign-extended
                r.mnemonic  = MN_LUI;
                r.immediate = {1'b0, w[31:12]};
                use_rd      = 1'b1;
            end
            default:
            begin
                r.mnemonic = MN_NONE;
            end
        endcase
        if (r.mnemonic == MN_NONE)
            return '0;
        r.dest_reg = use_rd  ? w[11:7]  : '0;
        r.src1_reg = use_rs1 ? w[19:15] : '0;
        r.src2_reg = use_rs2 ? w[24:20] : '0;
        return r;
    endfunction

    task automatic compare_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        rvd_result_t got;
        rvd_result_t want;
        if (rst_n)
        begin
            // pop before push so a same-edge word can't cover a stray result
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[PAYLOAD_W-1:0];
                if (decoded_q.size() == 0)
                begin
                    $error("result beat with no decoded word waiting: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    compare_field("mnemonic", want.mnemonic, got.mnemonic);
                    compare_field("dest_reg", want.dest_reg, got.dest_reg);
                    compare_field("src1_reg", want.src1_reg, got.src1_reg);
                    compare_field("src2_reg", want.src2_reg, got.src2_reg);
                    compare_field("immediate", $signed(want.immediate),
                                  $signed(got.immediate));
                    compare_field("padding", 0, m_tdata[OUT_W-1:PAYLOAD_W]);
                end
            end
            if (s_tvalid && s_tready)
                decoded_q.push_back(decode_word(s_tdata));
        end
        pending_results <= decoded_q.size();
        fail_count      <= errors;
    end

endmodule

// File: test/rv64i_instruction_decoder_tb.sv
// Testbench top for rv64i_instruction_decoder: clock, reset, bursty word
// source and stalling result sink; checking is done in the checker module.
// Depends on rvd_pkg, the decoder RTL and rv64i_instruction_decoder_checker.
`timescale 1ns / 100ps

module rv64i_instruction_decoder_tb;

    import rvd_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 8;      // two-stage pipe plus margin
    localparam int TIMEOUT_NS   = 400000;

    // funct3 values used by the directed words
    localparam logic [2:0] F3_LD       = 3'd3;
    localparam logic [2:0] F3_LWU      = 3'd6;
    localparam logic [2:0] F3_LOAD_BAD = 3'd7;
    localparam logic [2:0] F3_JALR_ODD = 3'd7;
    localparam logic [2:0] F3_SW       = 3'd2;
    localparam logic [2:0] F3_SD       = 3'd3;
    localparam logic [2:0] F3_ST_BAD   = 3'd4;
    localparam logic [2:0] F3_BEQ      = 3'd0;
    localparam logic [2:0] F3_BR_BAD   = 3'd2;
    localparam logic [2:0] F3_BGEU     = 3'd7;
    localparam logic [2:0] F3_ALL      = 3'd7;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [INSTR_W-1:0]  s_tdata  = '0;   // [31:0] instr_word
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;         // [5:0] mnemonic, [10:6] dest_reg,
                                          // [15:11] src1_reg, [20:16] src2_reg,
                                          // [41:21] immediate, [47:42] zero
    int                  fails;
    int                  pending;

    always #1 clk = ~clk;

    rv64i_instruction_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rv64i_instruction_decoder_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fails),
        .pending_results (pending)
    );

    function automatic logic [INSTR_W-1:0] encode_word(input logic [6:0] op,
        input logic [2:0] f3, input logic [6:0] f7, input logic [4:0] rd,
        input logic [4:0] rs1, input logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    // mostly well-formed words with random fields, some raw noise and
    // some with a corrupted opcode bit
    function automatic logic [INSTR_W-1:0] random_word();
        logic [INSTR_W-1:0] w;
        int                 roll;
        w    = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return w;
        case ($urandom_range(0, 7))
            0: w[6:0] = OP_R;
            1: w[6:0] = OP_IMM;
            2: w[6:0] = OP_LOAD;
            3: w[6:0] = OP_JALR;
            4: w[6:0] = OP_STORE;
            5: w[6:0] = OP_BRANCH;
            6: w[6:0] = OP_JAL;
            default: w[6:0] = OP_LUI;
        endcase
        if (w[6:0] == OP_R)
        begin
            case ($urandom_range(0, 3))
                0, 1: w[31:25] = F7_BASE;
                2:    w[31:25] = F7_ALT;
                default: ;
            endcase
        end
        if (w[6:0] == OP_IMM && (w[14:12] == F3_SLL || w[14:12] == F3_SRL))
        begin
            case ($urandom_range(0, 3))
                0, 1: w[31:26] = F6_BASE;
                2:    w[31:26] = F6_SRA;
                default: ;
            endcase
        end
        if (roll < 17)
            w[$urandom_range(0, 6)] ^= 1'b1;
        return w;
    endfunction

    // hold the beat until the decoder takes it; tvalid stays up afterwards
    task automatic send_word(input logic [INSTR_W-1:0] w);
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_directed();
        send_word('0);                                             // all zero
        send_word('1);                                             // all ones
        send_word(encode_word(OP_R, F3_ADD, F7_BASE, 5'd31, 5'd31, 5'd31));
        send_word(encode_word(OP_R, F3_ADD, F7_ALT, 5'd1, 5'd2, 5'd3));  // sub
        send_word(encode_word(OP_R, F3_SRL, F7_ALT, 5'd5, 5'd6, 5'd7));  // sra
        send_word(encode_word(OP_R, F3_SLL, F7_ALT, 5'd8, 5'd9, 5'd10)); // bad f7
        send_word(encode_word(OP_R, F3_ADD, 7'h7F, 5'd8, 5'd9, 5'd10));
        send_word(encode_word(OP_LOAD, F3_LD, 7'h40, 5'd4, 5'd31, 5'd0));
        send_word(encode_word(OP_LOAD, F3_LWU, 7'h3F, 5'd31, 5'd0, 5'd31));
        send_word(encode_word(OP_LOAD, F3_LOAD_BAD, 7'h12, 5'd3, 5'd3, 5'd3));
        send_word(encode_word(OP_JALR, F3_ADD, 7'h00, 5'd1, 5'd2, 5'd9));
        // jalr with a nonzero funct3 still decodes
        send_word(encode_word(OP_JALR, F3_JALR_ODD, 7'h7F, 5'd31, 5'd31, 5'd31));
        send_word(encode_word(OP_IMM, F3_ADD, 7'h7F, 5'd12, 5'd13, 5'd31));
        send_word(encode_word(OP_IMM, F3_SLL, 7'h01, 5'd14, 5'd15, 5'd31)); // shamt 63
        send_word(encode_word(OP_IMM, F3_SRL, 7'h00, 5'd16, 5'd17, 5'd0));
        send_word(encode_word(OP_IMM, F3_SRL, {F6_SRA, 1'b1}, 5'd18, 5'd19, 5'd31));
        // shift words with upper bits that match no shift kind
        send_word(encode_word(OP_IMM, F3_SLL, {F6_SRA, 1'b0}, 5'd2, 5'd2, 5'd2));
        send_word(encode_word(OP_IMM, F3_SRL, 7'h7E, 5'd2, 5'd2, 5'd2));
        send_word(encode_word(OP_STORE, F3_SD, 7'h40, 5'd0, 5'd20, 5'd21));
        send_word(encode_word(OP_STORE, F3_SW, 7'h3F, 5'd31, 5'd22, 5'd23));
        send_word(encode_word(OP_STORE, F3_ST_BAD, 7'h05, 5'd6, 5'd6, 5'd6));
        send_word(encode_word(OP_BRANCH, F3_BEQ, 7'h40, 5'd0, 5'd24, 5'd25));
        send_word(encode_word(OP_BRANCH, F3_BGEU, 7'h3F, 5'd31, 5'd26, 5'd27));
        send_word(encode_word(OP_BRANCH, F3_BR_BAD, 7'h11, 5'd7, 5'd7, 5'd7));
        send_word(encode_word(OP_JAL, F3_ADD, 7'h40, 5'd1, 5'd0, 5'd0));     // most negative
        send_word(encode_word(OP_JAL, F3_ALL, 7'h3F, 5'd30, 5'd31, 5'd31));  // most positive
        send_word(encode_word(OP_LUI, F3_ALL, 7'h7F, 5'd29, 5'd31, 5'd31));
        send_word(encode_word(OP_LUI, F3_ADD, 7'h00, 5'd31, 5'd0, 5'd0));
    endtask

    // sink: ready pattern follows a randomly redrawn mode
    int rx_cycle = 0;
    int rx_mode  = 0;
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 97 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= rx_cycle[2];
        endcase
    end

    initial
    begin : stimulus
        int burst_left;
        int gap;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        // bursts of random length; now and then a long unbroken one
        burst_left = $urandom_range(1, 16);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_word(random_word());
            burst_left--;
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 16);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain: wait for every decoded word to come back, then a few more
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0 && pending == 0)
            $display("rv64i_instruction_decoder verification clean");
        else
            $display("rv64i_instruction_decoder verification failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("rv64i_instruction_decoder verification failed");
        $finish;
    end

endmodule
